@@ sv/tel_pkg.sv @@
// Shared types and constants for the TTL expiry lookup table.
package tel_pkg;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_KEY_WIDTH   = 32;
  localparam int DEF_TIME_WIDTH  = 32;

  localparam int          TTL_WIDTH   = 32;
  localparam logic [31:0] TTL_RESET   = 32'd1000;
  localparam int          PADDR_WIDTH = 3;
  localparam int          PDATA_WIDTH = 32;

  // Register index, taken from the word address of the configuration port.
  localparam logic REG_TTL = 1'b0;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_SWEEP  = 2'd2,
    CMD_FLUSH  = 2'd3
  } cmd_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the command and its operands
    logic issue;   // read the entry at the scan address and advance
    logic commit;  // apply the final update and present the result
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;  // the scan address points at the last entry
  } dp_stat_t;

endpackage

@@ sv/tel_ctrl.sv @@
// Controller state machine for the TTL expiry lookup table.
module tel_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  tel_pkg::dp_stat_t     stat,
  output tel_pkg::ctrl_cmd_t    cmd,
  output logic                  busy
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_TAIL   = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.scan_last) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

@@ sv/tel_dp.sv @@
// Datapath of the TTL expiry lookup table: entry memories, valid bits and counters.
module tel_dp #(
  parameter int TABLE_DEPTH = tel_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = tel_pkg::DEF_KEY_WIDTH,
  parameter int TIME_WIDTH  = tel_pkg::DEF_TIME_WIDTH,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tel_pkg::ctrl_cmd_t            cmd,
  output tel_pkg::dp_stat_t             stat,
  input  logic [1:0]                    command,
  input  logic [KEY_WIDTH-1:0]          key,
  input  logic [TIME_WIDTH-1:0]         now,
  input  logic [tel_pkg::TTL_WIDTH-1:0] ttl,
  output logic                          hit,
  output logic                          stored,
  output logic                          dropped,
  output logic [CW-1:0]                 removed,
  output logic [CW-1:0]                 occupancy,
  output logic                          done
);

  localparam int SW = ((TIME_WIDTH > tel_pkg::TTL_WIDTH) ? TIME_WIDTH : tel_pkg::TTL_WIDTH) + 1;

  logic [KEY_WIDTH-1:0]  key_mem [TABLE_DEPTH];
  logic [TIME_WIDTH-1:0] exp_mem [TABLE_DEPTH];

  tel_pkg::cmd_t         cmd_q;
  logic [KEY_WIDTH-1:0]  key_q;
  logic [TIME_WIDTH-1:0] now_q;
  logic [TIME_WIDTH-1:0] new_exp;

  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         rd_idx;
  logic                  rd_live;
  logic                  rd_vld;
  logic [KEY_WIDTH-1:0]  rd_key;
  logic [TIME_WIDTH-1:0] rd_exp;

  logic [TABLE_DEPTH-1:0] valid;
  logic [CW-1:0]          count, count_next;
  logic [CW-1:0]          rem_cnt;
  logic                   hit_f, found_f, free_f;
  logic [AW-1:0]          free_idx;

  logic [SW-1:0]          exp_sum;
  logic [TIME_WIDTH-1:0]  exp_sat;
  logic match, expd, lookup_hit, erase, first_free, insert, flush_now;
  logic exp_we, key_we;
  logic [AW-1:0] wr_addr;

  // Saturating expiry for the incoming command.
  always_comb begin
    exp_sum = SW'(now) + SW'(ttl);
    if (exp_sum[SW-1:TIME_WIDTH] != '0) begin
      exp_sat = '1;
    end else begin
      exp_sat = exp_sum[TIME_WIDTH-1:0];
    end
  end

  always_comb begin
    match      = rd_live && rd_vld && (rd_key == key_q);
    expd       = (now_q > rd_exp);
    lookup_hit = (cmd_q == tel_pkg::CMD_LOOKUP) && match && !expd;
    erase      = ((cmd_q == tel_pkg::CMD_LOOKUP) && match && expd) ||
                 ((cmd_q == tel_pkg::CMD_SWEEP) && rd_live && rd_vld && expd);
    first_free = (cmd_q == tel_pkg::CMD_STORE) && rd_live && !rd_vld && !free_f;
    insert     = cmd.commit && (cmd_q == tel_pkg::CMD_STORE) && !found_f && free_f;
    flush_now  = cmd.commit && (cmd_q == tel_pkg::CMD_FLUSH);
    exp_we     = lookup_hit || insert;
    key_we     = insert;
    wr_addr    = insert ? free_idx : rd_idx;
  end

  always_comb begin
    priority if (flush_now) begin
      count_next = '0;
    end else if (insert) begin
      count_next = count + CW'(1);
    end else if (erase) begin
      count_next = count - CW'(1);
    end else begin
      count_next = count;
    end
  end

  assign stat.scan_last = (rd_addr == AW'(TABLE_DEPTH - 1));

  // Entry memories: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_q;
    end
    if (exp_we) begin
      exp_mem[wr_addr] <= new_exp;
    end
    if (cmd.issue) begin
      rd_key <= key_mem[rd_addr];
      rd_exp <= exp_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      count   <= '0;
      rd_live <= 1'b0;
      done    <= 1'b0;
    end else begin
      rd_live <= cmd.issue;
      done    <= cmd.commit;
      count   <= count_next;
      if (erase) begin
        valid[rd_idx] <= 1'b0;
      end
      if (insert) begin
        valid[free_idx] <= 1'b1;
      end
      if (flush_now) begin
        valid <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q   <= tel_pkg::cmd_t'(command);
      key_q   <= key;
      now_q   <= now;
      new_exp <= exp_sat;
      rd_addr <= '0;
      rem_cnt <= '0;
      hit_f   <= 1'b0;
      found_f <= 1'b0;
      free_f  <= 1'b0;
    end else begin
      if (cmd.issue) begin
        rd_addr <= rd_addr + AW'(1);
      end
      if (erase) begin
        rem_cnt <= rem_cnt + CW'(1);
      end
      if (lookup_hit) begin
        hit_f <= 1'b1;
      end
      if ((cmd_q == tel_pkg::CMD_STORE) && match) begin
        found_f <= 1'b1;
      end
      if (first_free) begin
        free_f   <= 1'b1;
        free_idx <= rd_idx;
      end
    end
    if (cmd.issue) begin
      rd_idx <= rd_addr;
      rd_vld <= valid[rd_addr];
    end
    if (cmd.commit) begin
      hit       <= hit_f;
      stored    <= insert;
      dropped   <= (cmd_q == tel_pkg::CMD_STORE) && !found_f && !free_f;
      removed   <= flush_now ? count : rem_cnt;
      occupancy <= count_next;
    end
  end

endmodule

@@ sv/ttl_expiry_lookup_table.sv @@
// Top level of the TTL expiry lookup table with its configuration register.
//
// The block keeps up to TABLE_DEPTH keys, each with an expiry time. A command
// transfer takes place at a rising edge where start is high and busy is low;
// command, key and now are sampled at that edge. Lookup refreshes a live key
// and reports hit, or erases an expired one; store inserts an absent key in
// the lowest free entry or reports dropped when the table is full; sweep
// erases every expired entry; flush erases all entries.
// Every command scans the whole table, one entry per cycle through the single
// read port of the key and expiry memories; busy covers the scan, a tail state
// and a commit state, and done pulses for one cycle in the first cycle in which
// busy is low. A new command is only taken once the last one has finished, and
// a new command may be started in the very cycle in which done is high.
// The result transfer happens at the edge that ends the done cycle; the
// receiver cannot stall it, and the result ports hold their values until the
// next command finishes.
// The ttl register sits at byte address 0 of the APB port; the user must write it
// only while the block is idle, which the block does not enforce. Reset empties the
// table, sets ttl to 1000 and leaves the block idle and ready to accept a command at once.
module ttl_expiry_lookup_table #(
  parameter int TABLE_DEPTH = tel_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = tel_pkg::DEF_KEY_WIDTH,
  parameter int TIME_WIDTH  = tel_pkg::DEF_TIME_WIDTH,
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tel_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [tel_pkg::PDATA_WIDTH-1:0] pwdata,
  output logic [tel_pkg::PDATA_WIDTH-1:0] prdata,
  output logic                            pready,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      command,
  input  logic [KEY_WIDTH-1:0]            key,
  input  logic [TIME_WIDTH-1:0]           now,
  output logic                            done,
  output logic                            hit,
  output logic                            stored,
  output logic                            dropped,
  output logic [CW-1:0]                   removed,
  output logic [CW-1:0]                   occupancy
);

  logic [tel_pkg::TTL_WIDTH-1:0] ttl;
  logic                          cfg_write;
  logic                          reg_index;
  tel_pkg::ctrl_cmd_t            cmd;
  tel_pkg::dp_stat_t             stat;

  // The register index is the word address; only the ttl register exists.
  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ttl <= tel_pkg::TTL_RESET;
    end else if (cfg_write && (reg_index == tel_pkg::REG_TTL)) begin
      ttl <= pwdata[tel_pkg::TTL_WIDTH-1:0];
    end
  end

  assign prdata = (reg_index == tel_pkg::REG_TTL) ? ttl : '0;

  tel_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  tel_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .command   (command),
    .key       (key),
    .now       (now),
    .ttl       (ttl),
    .hit       (hit),
    .stored    (stored),
    .dropped   (dropped),
    .removed   (removed),
    .occupancy (occupancy),
    .done      (done)
  );

  // A result only follows a command that was in progress.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a command in progress");

  // An accepted command keeps the block busy in the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not make the block busy");

  // At most one of hit, stored and dropped is reported for one command.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot0({hit, stored, dropped}))
    else $error("conflicting result flags");

  // The occupancy can never exceed the table size.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (occupancy <= CW'(TABLE_DEPTH)))
    else $error("occupancy beyond table depth");

  // A hit or an insertion erases nothing.
  a_no_removal: assert property (@(posedge clk) disable iff (rst)
    (done && (hit || stored)) |-> (removed == '0))
    else $error("entries removed by a hit or a store");

endmodule
